// ===== hw/rtl/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMNS    = 80;
	localparam int DEF_ROWS_SHOWN = 25;

	localparam logic [15:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]  ATTR_RESET = 8'h07;

	// operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL       = 8'd0;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	// a tab stores eight spaces: one plus this many repeats
	localparam logic [2:0] TAB_REPEATS = 3'd7;

	// configuration register index (paddr[2])
	localparam logic REG_ATTRIBUTE = 1'b0;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ch;
		logic [10:0] cell_address;
		logic        end_of_write;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [10:0] cursor;
		logic [10:0] write_pos;
	} result_t;

	typedef enum logic [2:0] {
		K_IGNORE,
		K_NEWLINE,
		K_STORE,
		K_BACKSPACE,
		K_CLEAR,
		K_READ
	} kind_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_STORE,
		S_NL_CHECK,
		S_SCROLL,
		S_CLEAR,
		S_RESPOND
	} state_t;

	typedef struct packed {
		logic latch;
		logic blank_step;
		logic scroll_step;
		logic scroll_end;
		logic nl_adv;
		logic store;
		logic backspace;
		logic clear_pos;
		logic read_issue;
		logic respond;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  at_end;
		logic  col_zero;
		logic  rep_zero;
		logic  sc_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: decodes an item and steps the datapath
// through stores, newlines, backspaces, scrolls, clears and reads.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  tcw_pkg::dp_status_t    status,
	output tcw_pkg::ctrl_cmd_t     cmd
);
	import tcw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_INIT: begin
				// blank the screen after reset
				cmd.blank_step = 1'b1;
				if (status.sc_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (status.kind)
					K_NEWLINE: begin
						cmd.nl_adv = 1'b1;
						state_d    = S_NL_CHECK;
					end
					K_STORE: begin
						state_d = S_STORE;
					end
					K_BACKSPACE: begin
						cmd.backspace = !status.col_zero;
						state_d       = S_RESPOND;
					end
					K_CLEAR: begin
						cmd.clear_pos = 1'b1;
						state_d       = S_CLEAR;
					end
					K_READ: begin
						cmd.read_issue = 1'b1;
						state_d        = S_RESPOND;
					end
					default: begin
						state_d = S_RESPOND;
					end
				endcase
			end
			S_STORE: begin
				if (status.at_end) begin
					state_d = S_SCROLL;
				end else begin
					cmd.store = 1'b1;
					if (status.rep_zero) begin
						state_d = S_RESPOND;
					end
				end
			end
			S_NL_CHECK: begin
				state_d = status.at_end ? S_SCROLL : S_RESPOND;
			end
			S_SCROLL: begin
				cmd.scroll_step = 1'b1;
				if (status.sc_last) begin
					cmd.scroll_end = 1'b1;
					state_d = (status.kind == K_NEWLINE) ? S_RESPOND : S_STORE;
				end
			end
			S_CLEAR: begin
				cmd.blank_step = 1'b1;
				if (status.sc_last) begin
					state_d = S_RESPOND;
				end
			end
			S_RESPOND: begin
				cmd.respond = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, write position, column and cursor registers, sweep counter
// and result register of the console writer.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int COLUMNS    = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS_SHOWN = tcw_pkg::DEF_ROWS_SHOWN
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  tcw_pkg::item_t         item,
	input  wire  [7:0]             attribute,
	input  tcw_pkg::ctrl_cmd_t     cmd,
	output tcw_pkg::dp_status_t    status,
	output logic                   done,
	output tcw_pkg::result_t       result
);
	import tcw_pkg::*;

	localparam int CELLS      = COLUMNS * ROWS_SHOWN;
	localparam int COPY_CELLS = CELLS - COLUMNS;
	localparam int POS_W      = $clog2(CELLS + 1);
	localparam int PW1        = POS_W + 1;
	localparam int AW         = $clog2(CELLS);
	localparam int COL_W      = $clog2(COLUMNS);

	logic [15:0]      mem [CELLS];
	logic [15:0]      rdata_q;
	item_t            item_q;
	logic [2:0]       rep_q;
	logic             rd_ok_q;
	logic [POS_W-1:0] pos_q;
	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] cursor_q;
	logic [AW-1:0]    sc_q;
	logic             we_s1;
	logic [AW-1:0]    waddr_s1;
	logic [15:0]      wdata_s1;
	logic             use_rd_s1;
	result_t          result_q;
	logic             done_q;

	kind_t            kind;
	logic             put_mark;
	logic             sc_last;
	logic             copy;
	logic             in_range;
	logic             rd_en;
	logic [AW-1:0]    raddr;
	logic [7:0]       store_byte;
	logic [PW1-1:0]   nl_sum;
	logic [POS_W-1:0] nl_pos;
	logic [POS_W-1:0] pos_dec;
	logic [COL_W-1:0] col_inc;

	always_comb begin
		case (item_q.op)
			OP_PUT: begin
				case (item_q.ch)
					CH_NUL:       kind = K_IGNORE;
					CH_NEWLINE:   kind = K_NEWLINE;
					CH_BACKSPACE: kind = K_BACKSPACE;
					default:      kind = K_STORE;
				endcase
			end
			OP_CLEAR: kind = K_CLEAR;
			OP_READ:  kind = K_READ;
			default:  kind = K_IGNORE;
		endcase
	end

	assign put_mark   = (item_q.op == OP_PUT) && item_q.end_of_write;
	assign sc_last    = (sc_q == AW'(CELLS - 1));
	assign copy       = (sc_q < AW'(COPY_CELLS));
	assign in_range   = (32'(item_q.cell_address) < 32'(CELLS));
	assign store_byte = (item_q.ch == CH_TAB) ? CH_SPACE : item_q.ch;
	assign pos_dec    = pos_q - 1'b1;
	assign col_inc    = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;

	// next row start, saturated at the end of the screen (a scroll follows)
	assign nl_sum = {1'b0, pos_q} + PW1'(COLUMNS) - PW1'(col_q);
	assign nl_pos = (nl_sum >= PW1'(CELLS)) ? POS_W'(CELLS) : nl_sum[POS_W-1:0];

	assign rd_en = (cmd.read_issue && in_range) || (cmd.scroll_step && copy);
	assign raddr = cmd.read_issue ? AW'(item_q.cell_address) : sc_q + AW'(COLUMNS);

	assign status.kind     = kind;
	assign status.at_end   = (pos_q >= POS_W'(CELLS));
	assign status.col_zero = (col_q == '0);
	assign status.rep_zero = (rep_q == '0);
	assign status.sc_last  = sc_last;

	// screen memory: one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (we_s1) begin
			mem[waddr_s1] <= use_rd_s1 ? rdata_q : wdata_s1;
		end
	end

	// write stage: a scroll copy writes in the cycle after its read
	always_ff @(posedge clk) begin
		use_rd_s1 <= cmd.scroll_step && copy;
		wdata_s1  <= BLANK_CELL;
		waddr_s1  <= sc_q;
		if (cmd.store) begin
			wdata_s1 <= {attribute, store_byte};
			waddr_s1 <= AW'(pos_q);
		end else if (cmd.backspace) begin
			waddr_s1 <= AW'(pos_dec);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.read_issue) begin
			rd_ok_q <= in_range;
		end
		if (cmd.respond) begin
			result_q.cell_data <= (kind == K_READ && rd_ok_q) ? rdata_q : 16'd0;
			result_q.cursor    <= 11'(put_mark ? pos_q : cursor_q);
			result_q.write_pos <= 11'(pos_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1    <= 1'b0;
			done_q   <= 1'b0;
			pos_q    <= '0;
			col_q    <= '0;
			cursor_q <= '0;
			sc_q     <= '0;
			rep_q    <= '0;
		end else begin
			we_s1  <= cmd.blank_step || cmd.scroll_step || cmd.store || cmd.backspace;
			done_q <= cmd.respond;
			// sweeps wrap to zero on their last cell
			if (cmd.blank_step || cmd.scroll_step) begin
				sc_q <= sc_last ? '0 : sc_q + 1'b1;
			end
			if (cmd.latch) begin
				rep_q <= (item.ch == CH_TAB) ? TAB_REPEATS : 3'd0;
			end else if (cmd.store) begin
				rep_q <= rep_q - 1'b1;
			end
			if (cmd.clear_pos) begin
				pos_q <= '0;
				col_q <= '0;
			end else if (cmd.nl_adv) begin
				pos_q <= nl_pos;
				col_q <= '0;
			end else if (cmd.store) begin
				pos_q <= pos_q + 1'b1;
				col_q <= col_inc;
			end else if (cmd.backspace) begin
				pos_q <= pos_dec;
				col_q <= col_q - 1'b1;
			end else if (cmd.scroll_end) begin
				pos_q <= POS_W'(COPY_CELLS);
				col_q <= '0;
			end
			if (cmd.clear_pos) begin
				cursor_q <= '0;
			end else if (cmd.respond && put_mark) begin
				cursor_q <= pos_q;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(CELLS))
		else $error("write position beyond screen end");

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> pos_q < POS_W'(CELLS))
		else $error("character stored past screen end without scroll");

	a_store_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> pos_q == $past(pos_q) + 1'b1)
		else $error("store did not advance write position");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_writer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character terminal over a COLUMNS x ROWS_SHOWN screen of 16-bit cells.
//
// An item (put character, clear screen, read cell) is transferred at a clock
// edge with start high and busy low. Each item gives one result, shown on
// result for the single cycle in which done is high; the receiver cannot
// stall it. The attribute register (APB, address 0, reset 0x07) must only be
// written while the block is idle.
//
// The done cycle is also the earliest in which the next item can be
// transferred. A stored character or a newline that reaches the end of the
// screen first scrolls the single-port-write screen memory by one row, one
// cell copied per cycle; a clear blanks the whole screen. After reset busy
// stays high while the memory is blanked, one cell per cycle;
// configuration writes are taken during that sweep.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
	parameter int COLUMNS    = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS_SHOWN = tcw_pkg::DEF_ROWS_SHOWN
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  tcw_pkg::item_t       item,
	output logic                 done,
	output tcw_pkg::result_t     result,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [2:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import tcw_pkg::*;

	logic [7:0] attr_q;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ATTRIBUTE) ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTRIBUTE) begin
			attr_q <= pwdata[7:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	tcw_datapath #(
		.COLUMNS    (COLUMNS),
		.ROWS_SHOWN (ROWS_SHOWN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.attribute (attr_q),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire
